// File: rtl/msps_pkg.sv
// Package for the multi-channel servo pulse sequencer.
// Holds the command codes, the reset tables and the scaling constants;
// it depends on nothing else.
package msps_pkg;

  // Command carried by one input item.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_LIMITS = 2'd1,
    OP_MOVE   = 2'd2,
    OP_POT    = 2'd3
  } op_e;

  localparam int unsigned NUM_CHANNELS_DEF = 5;
  localparam int unsigned WIDTH_BITS_DEF   = 16;

  localparam int unsigned FRAME_BITS  = 16;
  localparam int unsigned CHAN_BITS   = 3;
  localparam int unsigned DELTA_BITS  = 13;
  localparam int unsigned LIMIT_BITS  = 16;
  localparam int unsigned REPORT_BITS = 16;
  localparam int unsigned PIN_COUNT   = 5;

  localparam logic [FRAME_BITS-1:0] FRAME_RESET = 16'd12500;

  // The potentiometer full scale is 2**POT_BITS - 1, which lets the
  // division be folded into shifts and adds.
  localparam int unsigned POT_BITS    = 10;
  localparam int unsigned POT_FULL    = (1 << POT_BITS) - 1;
  localparam int unsigned EDGE_MARGIN = 5;

  localparam int unsigned TABLE_SIZE = 16;

  localparam logic [31:0] WIDTH_INIT [TABLE_SIZE] = '{
    32'd900, 32'd1310, 32'd1510, 32'd750, 32'd2500, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };
  localparam logic [31:0] MIN_INIT [TABLE_SIZE] = '{
    32'd300, 32'd370, 32'd510, 32'd260, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };
  localparam logic [31:0] MAX_INIT [TABLE_SIZE] = '{
    32'd1500, 32'd1310, 32'd1510, 32'd1600, 32'd5000, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Reset width of a channel; channels past the table reset to zero.
  function automatic logic [31:0] width_init(input int unsigned k);
    logic [31:0] v;
    v = '0;
    if (k < TABLE_SIZE) begin
      v = WIDTH_INIT[k[$clog2(TABLE_SIZE)-1:0]];
    end
    return v;
  endfunction

  // Sum of the reset widths of the first n channels, each masked to w bits.
  function automatic logic [63:0] init_sum(input int unsigned n, input int unsigned w);
    logic [63:0] s;
    logic [63:0] mask;
    s    = '0;
    mask = (64'd1 << w) - 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      s = s + ({32'd0, width_init(k)} & mask);
    end
    return s;
  endfunction

endpackage

// File: rtl/msps_pot_scale.sv
// Potentiometer scaling for the servo sequencer: min + pot*(max-min)/1023,
// clamped inside the limits by the edge margin and saturated to the width.
// Depends on msps_pkg.
module msps_pot_scale #(
  parameter int unsigned WIDTH_BITS = msps_pkg::WIDTH_BITS_DEF
) (
  input  logic [msps_pkg::POT_BITS+WIDTH_BITS-1:0] prod_i,
  input  logic [WIDTH_BITS-1:0]                    low_i,
  input  logic [WIDTH_BITS-1:0]                    high_i,
  output logic [WIDTH_BITS-1:0]                    width_o
);
  import msps_pkg::*;

  localparam int unsigned PW = POT_BITS + WIDTH_BITS;
  localparam int unsigned NT = PW / POT_BITS + 1;
  localparam int unsigned SW = WIDTH_BITS + 2;

  logic [PW:0]            est;
  logic [PW:0]            q_est;
  logic [PW:0]            rem;
  logic [WIDTH_BITS-1:0]  quot;
  logic signed [SW-1:0]   lo_s;
  logic signed [SW-1:0]   hi_s;
  logic signed [SW-1:0]   top_s;
  logic signed [SW-1:0]   bot_s;
  logic signed [SW-1:0]   pos_s;
  logic signed [SW-1:0]   res_s;

  // x/1023 is x/1024 times 1 + 1/1024 + 1/1024^2 + ...; the truncated
  // series undershoots by at most one, which the remainder check repairs.
  always_comb begin
    est = '0;
    for (int unsigned k = 0; k < NT; k++) begin
      est = est + (PW+1)'(prod_i >> (k * POT_BITS));
    end
    q_est = est >> POT_BITS;
    rem   = {1'b0, prod_i} - (q_est << POT_BITS) + q_est;
    quot  = WIDTH_BITS'(q_est) + WIDTH_BITS'(rem >= (PW+1)'(POT_FULL));
  end

  always_comb begin
    lo_s  = $signed({2'b00, low_i});
    hi_s  = $signed({2'b00, high_i});
    top_s = hi_s - SW'(EDGE_MARGIN);
    bot_s = lo_s + SW'(EDGE_MARGIN);
    pos_s = lo_s + $signed({2'b00, quot});
    if (hi_s < lo_s) begin
      res_s = top_s;
    end else if (pos_s > top_s) begin
      res_s = top_s;
    end else if (pos_s < bot_s) begin
      res_s = bot_s;
    end else begin
      res_s = pos_s;
    end
    if (res_s < 0) begin
      width_o = '0;
    end else if (res_s[SW-1:WIDTH_BITS] != 2'b00) begin
      width_o = '1;
    end else begin
      width_o = res_s[WIDTH_BITS-1:0];
    end
  end

endmodule

// File: rtl/multi_servo_pulse_sequencer.sv
// Top level of the multi-channel servo pulse sequencer.
// Depends on msps_pkg and msps_pot_scale.
//
// Every input item is either one timer tick or one command on a channel's
// limits or width, and the block takes one item per clock while input
// ready is high. An item is held in the input register, where the addressed
// channel's width and limits are read and the potentiometer product is
// formed, and then passes through the command and phase logic, whose
// result is held in the output register until it is taken. Input
// ready drops only while both registers are full and the output is not
// being taken. The channel widths sit in a small register file whose
// reset values come from per-entry valid bits, so there is no clearing
// pass after reset. The frame period may be written whenever the block
// is idle and takes effect on the next gap.
module multi_servo_pulse_sequencer #(
  parameter int unsigned NUM_CHANNELS = msps_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned WIDTH_BITS   = msps_pkg::WIDTH_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [msps_pkg::FRAME_BITS-1:0]       cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            op_i,
  input  logic [msps_pkg::CHAN_BITS-1:0]        channel_i,
  input  logic signed [msps_pkg::DELTA_BITS-1:0] delta_i,
  input  logic [msps_pkg::POT_BITS-1:0]         pot_value_i,
  input  logic [msps_pkg::LIMIT_BITS-1:0]       low_limit_i,
  input  logic [msps_pkg::LIMIT_BITS-1:0]       high_limit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [msps_pkg::PIN_COUNT-1:0]        servo_pins_o,
  output logic                                  frame_start_o,
  output logic                                  applied_o,
  output logic [msps_pkg::REPORT_BITS-1:0]      width_now_o
);
  import msps_pkg::*;

  localparam int unsigned AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PHW = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned SUMW = WIDTH_BITS + $clog2(NUM_CHANNELS + 1);
  localparam int unsigned TW  = (WIDTH_BITS > FRAME_BITS) ? WIDTH_BITS : FRAME_BITS;
  localparam int unsigned PW  = POT_BITS + WIDTH_BITS;
  localparam int unsigned CW  = ((WIDTH_BITS > DELTA_BITS) ? WIDTH_BITS : DELTA_BITS) + 2;
  localparam int unsigned GW  = ((SUMW > FRAME_BITS) ? SUMW : FRAME_BITS) + 2;
  localparam logic [PHW-1:0]  GAP_PHASE = PHW'(NUM_CHANNELS);
  localparam logic [SUMW-1:0] SUM_RESET = SUMW'(init_sum(NUM_CHANNELS, WIDTH_BITS));

  // Configuration.
  logic [FRAME_BITS-1:0] frame_q;

  // Channel storage.
  logic [WIDTH_BITS-1:0] pw_mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] pw_vld_q;
  logic [WIDTH_BITS-1:0] min_q [NUM_CHANNELS];
  logic [WIDTH_BITS-1:0] max_q [NUM_CHANNELS];
  logic [SUMW-1:0]       sum_q, sum_d;

  // Sequencer state.
  logic [PHW-1:0]        phase_q, phase_d;
  logic [TW-1:0]         tick_q, tick_d;
  logic                  live_q, live_d;
  logic [WIDTH_BITS-1:0] nxt_width_q;
  logic [PHW-1:0]        nxt_ph;

  // Input stage.
  logic                  s1_valid_q;
  op_e                   s1_op_q;
  logic                  s1_ok_q;
  logic [AW-1:0]         s1_addr_q;
  logic signed [DELTA_BITS-1:0] s1_delta_q;
  logic [WIDTH_BITS-1:0] s1_lo_in_q, s1_hi_in_q;
  logic [WIDTH_BITS-1:0] s1_width_q, s1_min_q, s1_max_q;
  logic [PW-1:0]         s1_prod_q;

  // Output register.
  logic                  out_valid_q;
  logic [PIN_COUNT-1:0]  out_pins_q;
  logic                  out_start_q, out_applied_q;
  logic [REPORT_BITS-1:0] out_width_q;

  logic                  accept, adv;
  logic [AW-1:0]         in_addr;
  logic                  in_ok;
  logic [WIDTH_BITS-1:0] lo0, hi0;
  logic [PW-1:0]         prod0;

  logic                  wr_pw, wr_lim;
  logic [WIDTH_BITS-1:0] new_w, pot_w, width_after;
  logic [WIDTH_BITS:0]   centre_sum;
  logic signed [CW-1:0]  cand;
  logic                  move_ok;
  logic                  starts;
  logic signed [GW-1:0]  gap;
  logic [PIN_COUNT-1:0]  pins_d;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------
  // Read side of the input stage, with bypass from the write in progress.
  // ---------------------------------------------------------------------
  assign in_addr = AW'(channel_i);
  assign in_ok   = 32'(channel_i) < NUM_CHANNELS;

  always_comb begin
    lo0 = '0;
    hi0 = '0;
    if (in_ok) begin
      if (wr_lim && s1_addr_q == in_addr) begin
        lo0 = s1_lo_in_q;
        hi0 = s1_hi_in_q;
      end else begin
        lo0 = min_q[in_addr];
        hi0 = max_q[in_addr];
      end
    end
    prod0 = PW'(pot_value_i) * PW'(hi0 - lo0);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= op_e'(op_i);
      s1_ok_q    <= in_ok;
      s1_addr_q  <= in_addr;
      s1_delta_q <= delta_i;
      s1_lo_in_q <= WIDTH_BITS'(low_limit_i);
      s1_hi_in_q <= WIDTH_BITS'(high_limit_i);
      s1_min_q   <= lo0;
      s1_max_q   <= hi0;
      s1_prod_q  <= prod0;
      if (!in_ok) begin
        s1_width_q <= '0;
      end else if (wr_pw && s1_addr_q == in_addr) begin
        s1_width_q <= new_w;
      end else if (pw_vld_q[in_addr]) begin
        s1_width_q <= pw_mem[in_addr];
      end else begin
        s1_width_q <= WIDTH_BITS'(width_init(32'(in_addr)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Command and phase logic.
  // ---------------------------------------------------------------------
  msps_pot_scale #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_pot_scale (
    .prod_i  (s1_prod_q),
    .low_i   (s1_min_q),
    .high_i  (s1_max_q),
    .width_o (pot_w)
  );

  always_comb begin
    centre_sum = {1'b0, s1_lo_in_q} + {1'b0, s1_hi_in_q};
    cand       = $signed({{(CW-WIDTH_BITS){1'b0}}, s1_width_q}) + CW'(s1_delta_q);
    move_ok    = (cand >= $signed({{(CW-WIDTH_BITS){1'b0}}, s1_min_q})) &&
                 (cand <= $signed({{(CW-WIDTH_BITS){1'b0}}, s1_max_q}));
    wr_pw  = 1'b0;
    wr_lim = 1'b0;
    new_w  = s1_width_q;
    case (s1_op_q)
      OP_TICK: begin
        new_w = s1_width_q;
      end
      OP_LIMITS: begin
        wr_pw  = adv && s1_ok_q;
        wr_lim = adv && s1_ok_q;
        new_w  = centre_sum[WIDTH_BITS:1];
      end
      OP_MOVE: begin
        wr_pw = adv && s1_ok_q && move_ok;
        new_w = cand[WIDTH_BITS-1:0];
      end
      OP_POT: begin
        wr_pw = adv && s1_ok_q;
        new_w = pot_w;
      end
      default: begin
        new_w = s1_width_q;
      end
    endcase
    width_after = wr_pw ? new_w : s1_width_q;
    sum_d = sum_q;
    if (wr_pw) begin
      sum_d = sum_q - SUMW'(s1_width_q) + SUMW'(new_w);
    end
  end

  // A phase of length L loads L-1 on entry and counts down to zero; the
  // tick that finds zero enters the next phase.
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    live_d  = live_q;
    starts  = 1'b0;
    gap     = $signed({{(GW-FRAME_BITS){1'b0}}, frame_q}) -
              $signed({{(GW-SUMW){1'b0}}, sum_q});
    if (adv && s1_op_q == OP_TICK) begin
      if (tick_q != '0) begin
        tick_d = tick_q - TW'(1);
      end else begin
        if (phase_q == GAP_PHASE) begin
          phase_d = '0;
          starts  = 1'b1;
        end else begin
          phase_d = phase_q + PHW'(1);
        end
        if (phase_d != GAP_PHASE) begin
          live_d = nxt_width_q != '0;
          tick_d = (nxt_width_q != '0) ? TW'(nxt_width_q - WIDTH_BITS'(1)) : '0;
        end else begin
          live_d = 1'b0;
          tick_d = (gap < 1) ? '0 : TW'(gap - GW'(1));
        end
      end
    end
    for (int unsigned k = 0; k < PIN_COUNT; k++) begin
      pins_d[k] = live_d && (phase_d != GAP_PHASE) && (32'(phase_d) == k);
    end
    nxt_ph = (phase_d == GAP_PHASE) ? '0 : phase_d + PHW'(1);
  end

  // ---------------------------------------------------------------------
  // State registers.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FRAME_RESET;
    end else if (cfg_we_i) begin
      frame_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_pw) begin
      pw_mem[s1_addr_q] <= new_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_vld_q <= '0;
    end else if (wr_pw) begin
      pw_vld_q[s1_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < NUM_CHANNELS; k++) begin
        min_q[k] <= WIDTH_BITS'(MIN_INIT[k]);
        max_q[k] <= WIDTH_BITS'(MAX_INIT[k]);
      end
    end else if (wr_lim) begin
      min_q[s1_addr_q] <= s1_lo_in_q;
      max_q[s1_addr_q] <= s1_hi_in_q;
    end
  end

  // Width of the channel that the next phase change will enter, kept one
  // step ahead so that a tick never waits on the width store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_width_q <= WIDTH_BITS'(width_init(0));
    end else if (32'(nxt_ph) < NUM_CHANNELS) begin
      if (wr_pw && s1_addr_q == AW'(nxt_ph)) begin
        nxt_width_q <= new_w;
      end else if (pw_vld_q[AW'(nxt_ph)]) begin
        nxt_width_q <= pw_mem[AW'(nxt_ph)];
      end else begin
        nxt_width_q <= WIDTH_BITS'(width_init(32'(nxt_ph)));
      end
    end else begin
      nxt_width_q <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= GAP_PHASE;
      tick_q  <= '0;
      live_q  <= 1'b0;
      sum_q   <= SUM_RESET;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      live_q  <= live_d;
      sum_q   <= sum_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pins_q    <= pins_d;
      out_start_q   <= starts;
      out_applied_q <= wr_pw;
      out_width_q   <= s1_ok_q ? REPORT_BITS'(width_after) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign servo_pins_o  = out_pins_q;
  assign frame_start_o = out_start_q;
  assign applied_o     = out_applied_q;
  assign width_now_o   = out_width_q;

endmodule

// File: verif/msps_servo_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the multi-channel servo pulse sequencer: it watches the frame
// period port and both item channels, predicts every result and compares it.
// Depends on msps_pkg for the command codes and the port widths.
module msps_servo_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [msps_pkg::FRAME_BITS-1:0]        cfg_wdata_i,
  input  logic                                   in_valid_i,
  input  logic                                   in_ready_i,
  input  logic [1:0]                             op_i,
  input  logic [msps_pkg::CHAN_BITS-1:0]         channel_i,
  input  logic signed [msps_pkg::DELTA_BITS-1:0] delta_i,
  input  logic [msps_pkg::POT_BITS-1:0]          pot_value_i,
  input  logic [msps_pkg::LIMIT_BITS-1:0]        low_limit_i,
  input  logic [msps_pkg::LIMIT_BITS-1:0]        high_limit_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_ready_i,
  input  logic [msps_pkg::PIN_COUNT-1:0]         servo_pins_i,
  input  logic                                   frame_start_i,
  input  logic                                   applied_i,
  input  logic [msps_pkg::REPORT_BITS-1:0]       width_now_i,
  output int unsigned                            errors_o,
  output int unsigned                            outstanding_o
);
  import msps_pkg::*;

  localparam int unsigned CHANNELS  = NUM_CHANNELS_DEF;
  localparam int unsigned GAP_PHASE = CHANNELS;
  localparam longint      MARGIN    = 5;
  localparam longint      POT_SCALE = 1023;
  localparam longint      WIDTH_MAX = (longint'(1) << WIDTH_BITS_DEF) - 1;

  typedef logic [WIDTH_BITS_DEF-1:0] width_t;

  localparam width_t RESET_WIDTH [CHANNELS] = '{900, 1310, 1510, 750, 2500};
  localparam width_t RESET_MIN   [CHANNELS] = '{300, 370, 510, 260, 0};
  localparam width_t RESET_MAX   [CHANNELS] = '{1500, 1310, 1510, 1600, 5000};

  typedef struct packed {
    logic [PIN_COUNT-1:0]   pins;
    logic                   frame_start;
    logic                   applied;
    logic [REPORT_BITS-1:0] width_now;
  } servo_report_t;

  servo_report_t   expected_reports[$];
  logic [15:0]     frame_period;
  width_t          width_q [CHANNELS];
  width_t          min_q [CHANNELS];
  width_t          max_q [CHANNELS];
  int unsigned     phase;
  longint          ticks_left;
  logic            pin_live;
  int unsigned     error_total = 0;

  function automatic void restore_reset_state();
    frame_period = FRAME_RESET;
    for (int k = 0; k < CHANNELS; k++) begin
      width_q[k] = RESET_WIDTH[k];
      min_q[k]   = RESET_MIN[k];
      max_q[k]   = RESET_MAX[k];
    end
    // The block wakes up in the gap with nothing left, so the first tick
    // starts a frame.
    phase      = GAP_PHASE;
    ticks_left = 0;
    pin_live   = 1'b0;
  endfunction

  function automatic width_t clamp_width(input longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > WIDTH_MAX) begin
      return width_t'(WIDTH_MAX);
    end
    return width_t'(v);
  endfunction

  // One timer tick; returns whether it entered the channel 0 pulse.
  function automatic logic advance_tick();
    logic   starts;
    longint width_sum;
    longint gap_len;
    starts = 1'b0;
    if (ticks_left != 0) begin
      ticks_left--;
      return 1'b0;
    end
    if (phase >= GAP_PHASE) begin
      phase  = 0;
      starts = 1'b1;
    end else begin
      phase++;
    end
    if (phase < GAP_PHASE) begin
      // A zero width still takes one tick, with the pin held low.
      pin_live   = (width_q[phase] != 0);
      ticks_left = pin_live ? longint'(width_q[phase]) - 1 : 0;
    end else begin
      width_sum = 0;
      for (int k = 0; k < CHANNELS; k++) begin
        width_sum += longint'(width_q[k]);
      end
      gap_len = longint'(frame_period) - width_sum;
      if (gap_len < 1) begin
        gap_len = 1;
      end
      pin_live   = 1'b0;
      ticks_left = gap_len - 1;
    end
    return starts;
  endfunction

  function automatic width_t scale_pot(input int unsigned ch, input logic [POT_BITS-1:0] pot);
    longint lo;
    longint hi;
    longint pos;
    lo = longint'(min_q[ch]);
    hi = longint'(max_q[ch]);
    if (hi < lo) begin
      return clamp_width(hi - MARGIN);
    end
    pos = lo + (longint'(pot) * (hi - lo)) / POT_SCALE;
    if (pos > hi - MARGIN) begin
      pos = hi - MARGIN;
    end else if (pos < lo + MARGIN) begin
      pos = lo + MARGIN;
    end
    return clamp_width(pos);
  endfunction

  function automatic servo_report_t predict_report(
    input op_e                         cmd,
    input logic [CHAN_BITS-1:0]        ch,
    input logic signed [DELTA_BITS-1:0] dlt,
    input logic [POT_BITS-1:0]         pot,
    input logic [LIMIT_BITS-1:0]       lo,
    input logic [LIMIT_BITS-1:0]       hi
  );
    servo_report_t r;
    logic          valid_ch;
    longint        cand;
    logic [16:0]   limit_sum;
    r        = '0;
    valid_ch = (ch < CHANNELS);
    case (cmd)
      OP_TICK: begin
        r.frame_start = advance_tick();
      end
      OP_LIMITS: begin
        if (valid_ch) begin
          limit_sum   = {1'b0, lo} + {1'b0, hi};
          min_q[ch]   = lo;
          max_q[ch]   = hi;
          width_q[ch] = width_t'(limit_sum >> 1);
          r.applied   = 1'b1;
        end
      end
      OP_MOVE: begin
        if (valid_ch) begin
          cand = longint'(width_q[ch]) + longint'(dlt);
          if (cand >= longint'(min_q[ch]) && cand <= longint'(max_q[ch])) begin
            width_q[ch] = width_t'(cand);
            r.applied   = 1'b1;
          end
        end
      end
      default: begin
        if (valid_ch) begin
          width_q[ch] = scale_pot(ch, pot);
          r.applied   = 1'b1;
        end
      end
    endcase
    if (phase < GAP_PHASE && pin_live) begin
      r.pins = PIN_COUNT'(1 << phase);
    end
    r.width_now = valid_ch ? REPORT_BITS'(width_q[ch]) : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    servo_report_t want;
    if (!rst_ni) begin
      restore_reset_state();
      expected_reports.delete();
      errors_o      <= error_total;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        frame_period = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_reports.push_back(predict_report(op_e'(op_i), channel_i, delta_i,
                                                  pot_value_i, low_limit_i, high_limit_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result with none expected, pins %b start %b applied %b width %0d",
                   $time, servo_pins_i, frame_start_i, applied_i, width_now_i);
          error_total++;
        end else begin
          want = expected_reports.pop_front();
          check_field("servo_pins", want.pins, servo_pins_i);
          check_field("frame_start", want.frame_start, frame_start_i);
          check_field("applied", want.applied, applied_i);
          check_field("width_now", want.width_now, width_now_i);
        end
      end
      errors_o      <= error_total;
      outstanding_o <= expected_reports.size();
    end
  end

endmodule

// File: verif/tb_multi_servo_pulse_sequencer.sv
`timescale 1ns / 100ps
// Top of the servo pulse sequencer testbench: clock, reset, item stimulus,
// output stalls and the verdict. Depends on msps_pkg, the block and msps_servo_checker.
module tb_multi_servo_pulse_sequencer;
  import msps_pkg::*;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [FRAME_BITS-1:0]        cfg_wdata;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   op;
  logic [CHAN_BITS-1:0]         channel;
  logic signed [DELTA_BITS-1:0] delta;
  logic [POT_BITS-1:0]          pot_value;
  logic [LIMIT_BITS-1:0]        low_limit;
  logic [LIMIT_BITS-1:0]        high_limit;
  logic                         out_valid;
  logic                         out_ready;
  logic [PIN_COUNT-1:0]         servo_pins;
  logic                         frame_start;
  logic                         applied;
  logic [REPORT_BITS-1:0]       width_now;
  int unsigned                  error_count;
  int unsigned                  outstanding;
  logic                         no_input_gaps;

  multi_servo_pulse_sequencer dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .op_i         (op),
    .channel_i    (channel),
    .delta_i      (delta),
    .pot_value_i  (pot_value),
    .low_limit_i  (low_limit),
    .high_limit_i (high_limit),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .servo_pins_o (servo_pins),
    .frame_start_o(frame_start),
    .applied_o    (applied),
    .width_now_o  (width_now)
  );

  msps_servo_checker servo_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .op_i         (op),
    .channel_i    (channel),
    .delta_i      (delta),
    .pot_value_i  (pot_value),
    .low_limit_i  (low_limit),
    .high_limit_i (high_limit),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .servo_pins_i (servo_pins),
    .frame_start_i(frame_start),
    .applied_i    (applied),
    .width_now_i  (width_now),
    .errors_o     (error_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic push_item(
    input op_e                         cmd,
    input logic [CHAN_BITS-1:0]        ch,
    input logic signed [DELTA_BITS-1:0] dlt,
    input logic [POT_BITS-1:0]         pot,
    input logic [LIMIT_BITS-1:0]       lo,
    input logic [LIMIT_BITS-1:0]       hi
  );
    int unsigned idle;
    idle = no_input_gaps ? 0 : pick_gap();
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= cmd;
    channel    <= ch;
    delta      <= dlt;
    pot_value  <= pot;
    low_limit  <= lo;
    high_limit <= hi;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_random_item();
    op_e                         cmd;
    int unsigned                 r;
    logic [CHAN_BITS-1:0]        ch;
    logic signed [DELTA_BITS-1:0] dlt;
    logic [POT_BITS-1:0]         pot;
    logic [LIMIT_BITS-1:0]       lo;
    logic [LIMIT_BITS-1:0]       hi;
    logic [LIMIT_BITS-1:0]       swap;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      cmd = OP_TICK;
    end else if (r < 67) begin
      cmd = OP_LIMITS;
    end else if (r < 85) begin
      cmd = OP_MOVE;
    end else begin
      cmd = OP_POT;
    end
    ch = ($urandom_range(0, 9) == 0) ? CHAN_BITS'($urandom_range(5, 7))
                                     : CHAN_BITS'($urandom_range(0, 4));
    dlt = ($urandom_range(0, 3) == 0) ? DELTA_BITS'($urandom)
                                      : DELTA_BITS'($urandom_range(0, 40)) - DELTA_BITS'(20);
    r = $urandom_range(0, 9);
    pot = (r == 0) ? '0 : (r == 1) ? '1 : POT_BITS'($urandom);
    // Small limits keep frames short, so that many of them pass.
    r = $urandom_range(0, 99);
    if (r < 80) begin
      lo = LIMIT_BITS'($urandom_range(0, 40));
      hi = LIMIT_BITS'($urandom_range(0, 40));
    end else if (r < 96) begin
      lo = LIMIT_BITS'($urandom_range(0, 300));
      hi = LIMIT_BITS'($urandom_range(0, 300));
    end else begin
      lo = LIMIT_BITS'($urandom);
      hi = LIMIT_BITS'($urandom);
    end
    // Reversed limits freeze a channel, so most of them are put in order.
    if (lo > hi && $urandom_range(0, 4) != 0) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    push_item(cmd, ch, dlt, pot, lo, hi);
  endtask

  // Lower valid and wait until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic set_frame_period(input logic [FRAME_BITS-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : out_ready_driver
    int unsigned run;
    int unsigned hold;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      hold = pick_gap();
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [FRAME_BITS-1:0] periods [6];
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    op            <= OP_TICK;
    channel       <= '0;
    delta         <= '0;
    pot_value     <= '0;
    low_limit     <= '0;
    high_limit    <= '0;
    out_ready     <= 1'b0;
    no_input_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Moves that leave the limits are refused; landing on either limit is allowed.
    push_item(OP_MOVE, 0, -13'sd4096, 0, 0, 0);
    push_item(OP_MOVE, 0, 13'sd4095, 0, 0, 0);
    push_item(OP_MOVE, 0, 13'sd600, 0, 0, 0);
    push_item(OP_MOVE, 0, -13'sd1200, 0, 0, 0);
    push_item(OP_POT, 1, 0, 10'd0, 0, 0);
    push_item(OP_POT, 1, 0, 10'd1023, 0, 0);
    push_item(OP_POT, 2, 0, 10'd511, 0, 0);
    // Reversed limits are stored as given and pin the pot result at the top.
    push_item(OP_LIMITS, 2, 0, 0, 16'd2000, 16'd100);
    push_item(OP_POT, 2, 0, 10'd300, 0, 0);
    push_item(OP_LIMITS, 3, 0, 0, 16'hFFFF, 16'hFFFF);
    push_item(OP_POT, 3, 0, 10'd777, 0, 0);
    // With both limits at zero the pot result saturates at zero.
    push_item(OP_LIMITS, 4, 0, 0, 16'd0, 16'd0);
    push_item(OP_POT, 4, 0, 10'd1023, 0, 0);
    push_item(OP_LIMITS, 1, 0, 0, 16'd0, 16'hFFFF);
    push_item(OP_MOVE, 1, 13'sd4095, 0, 0, 0);
    // Commands on channels that do not exist change nothing.
    push_item(OP_LIMITS, 5, -13'sd1, 10'd1023, 16'hFFFF, 16'hFFFF);
    push_item(OP_MOVE, 6, -13'sd4096, 10'd0, 16'd0, 16'd0);
    push_item(OP_POT, 7, 13'sd4095, 10'd1023, 16'hFFFF, 16'd0);
    // Short widths, channel 4 left at zero, then a few ticks into the frame.
    push_item(OP_LIMITS, 0, 0, 0, 16'd2, 16'd6);
    push_item(OP_LIMITS, 1, 0, 0, 16'd0, 16'd3);
    push_item(OP_LIMITS, 2, 0, 0, 16'd1, 16'd1);
    push_item(OP_LIMITS, 3, 0, 0, 16'd0, 16'd9);
    repeat (5) push_item(OP_TICK, 0, 0, 0, 0, 0);

    periods = '{16'd0, 16'd1, 16'd37, FRAME_BITS'($urandom_range(20, 400)),
                FRAME_BITS'($urandom_range(1, 65535)), 16'hFFFF};
    for (int p = 0; p < 6; p++) begin
      set_frame_period(periods[p]);
      no_input_gaps = (p % 3 == 1);
      repeat (150) send_random_item();
    end

    drain_results();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
